/* rtl/dfx_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dfx_pkg;

	localparam int BYTE_W    = 8;
	localparam int LEN_W     = 13;
	localparam int MARKER_W  = 16;
	localparam int CFG_IDX_W = 1;
	localparam int M_TDATA_W = 24;

	localparam int DEF_START_BYTES = 2;
	localparam int DEF_END_BYTES   = 2;
	localparam int DEF_MAX_FRAME   = 4096;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_END_MARKER   = 1'b1;

	// result kinds
	localparam logic KIND_PAYLOAD   = 1'b0;
	localparam logic KIND_FRAME_END = 1'b1;

	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] payload_byte;
		logic [LEN_W-1:0]  frame_length;
	} result_t;

endpackage

`default_nettype wire

/* rtl/dfx_core.sv */
`timescale 1ns / 1ps
`default_nettype none

module dfx_core #(
	parameter int START_BYTES = dfx_pkg::DEF_START_BYTES,
	parameter int END_BYTES   = dfx_pkg::DEF_END_BYTES,
	parameter int MAX_FRAME   = dfx_pkg::DEF_MAX_FRAME
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           step,
	input  wire logic [dfx_pkg::BYTE_W-1:0]     rx_byte,
	input  wire logic [dfx_pkg::MARKER_W-1:0]   start_marker,
	input  wire logic [dfx_pkg::MARKER_W-1:0]   end_marker,
	output logic                                res_valid,
	output dfx_pkg::result_t                    res
);
	import dfx_pkg::*;

	localparam int HIST_CAP = (START_BYTES > END_BYTES) ? START_BYTES : END_BYTES;
	localparam int HW = HIST_CAP * BYTE_W;
	localparam int SW = START_BYTES * BYTE_W;
	localparam int EW = END_BYTES * BYTE_W;
	localparam int CW = $clog2(HIST_CAP + 1);
	localparam int PW = $clog2(MAX_FRAME + 1);
	// bytes that stay in the window after the oldest one leaves
	localparam logic [HW-1:0] KEEP_MASK = HW'((65'(1) << (EW - BYTE_W)) - 65'(1));

	logic          in_frame_q;
	logic [HW-1:0] hist_q;
	logic [CW-1:0] cnt_q;
	logic [PW-1:0] pcount_q;

	logic [HW-1:0] hist_sh;
	logic [CW-1:0] cnt_inc;
	logic          start_hit;
	logic          end_hit;
	logic          emit;

	assign hist_sh   = HW'({hist_q, rx_byte});
	assign cnt_inc   = (cnt_q < CW'(HIST_CAP)) ? cnt_q + CW'(1) : cnt_q;
	assign start_hit = (cnt_inc >= CW'(START_BYTES)) && (hist_sh[SW-1:0] == SW'(start_marker));
	assign end_hit   = (cnt_inc >= CW'(END_BYTES)) && (hist_sh[EW-1:0] == EW'(end_marker));
	assign emit      = !end_hit && (cnt_inc >= CW'(END_BYTES));

	always_comb begin
		res = '0;
		res_valid = 1'b0;
		if (in_frame_q) begin
			if (end_hit) begin
				res_valid        = 1'b1;
				res.kind         = KIND_FRAME_END;
				res.frame_length = LEN_W'(pcount_q);
			end else if (emit) begin
				res_valid        = 1'b1;
				res.kind         = KIND_PAYLOAD;
				res.payload_byte = hist_sh[EW-1 -: BYTE_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			hist_q     <= '0;
			cnt_q      <= '0;
			pcount_q   <= '0;
		end else if (step) begin
			if (!in_frame_q) begin
				if (start_hit) begin
					in_frame_q <= 1'b1;
					hist_q     <= '0;
					cnt_q      <= '0;
					pcount_q   <= '0;
				end else begin
					hist_q <= hist_sh;
					cnt_q  <= cnt_inc;
				end
			end else if (end_hit) begin
				in_frame_q <= 1'b0;
				hist_q     <= '0;
				cnt_q      <= '0;
				pcount_q   <= '0;
			end else if (emit) begin
				// drop the emitted byte from the window
				hist_q <= hist_sh & KEEP_MASK;
				cnt_q  <= CW'(END_BYTES - 1);
				if (pcount_q < PW'(MAX_FRAME))
					pcount_q <= pcount_q + PW'(1);
			end else begin
				hist_q <= hist_sh;
				cnt_q  <= cnt_inc;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(HIST_CAP))
		else $error("byte count above window depth");

	a_pcount_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pcount_q <= PW'(MAX_FRAME))
		else $error("payload count above frame limit");

	a_hunt_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> pcount_q == '0)
		else $error("payload count not cleared while hunting");

	a_frame_end_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		step && res_valid && res.kind == KIND_FRAME_END |=> !in_frame_q && cnt_q == '0)
		else $error("frame end did not return to hunting");

endmodule

`default_nettype wire

/* rtl/dfx_out_stage.sv */
`timescale 1ns / 1ps
`default_nettype none

module dfx_out_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire logic              res_valid,
	input  wire dfx_pkg::result_t  res,
	input  wire logic              take,
	output logic                   out_valid,
	output dfx_pkg::result_t       out_res
);
	import dfx_pkg::*;

	logic    valid_q;
	result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= res_valid;
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && res_valid)
			res_q <= res;
	end

	assign out_valid = valid_q;
	assign out_res   = res_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !valid_q || take)
		else $error("result register loaded while holding an untaken request");

	a_kind_fields: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && res_q.kind == KIND_FRAME_END |-> res_q.payload_byte == '0)
		else $error("frame end carries a payload byte");

	a_payload_fields: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && res_q.kind == KIND_PAYLOAD |-> res_q.frame_length == '0)
		else $error("payload byte carries a length");

endmodule

`default_nettype wire

/* rtl/delimited_frame_extractor.sv */
// Start/end delimiter deframer.
// Input: one received byte per request on s_tvalid/s_tready/s_tdata.
// Output: one request per payload byte or frame end on m_tvalid/m_tready;
//   m_tuser = 0 marks a payload byte, 1 marks the end of a frame with its
//   length (saturating at MAX_FRAME) in the length field.
// While hunting, the block waits for the start pattern; inside a frame it
// holds bytes back END_BYTES deep so the end pattern is dropped, not emitted.
// Patterns are set through cfg_we/cfg_index/cfg_data; index 0 start pattern,
// index 1 end pattern, first byte in the most significant position.
// Write them only while no bytes are in flight.
// Path: an accepted byte waits in the input register until the result
// register is free or being taken, then its result is registered there.
// Throughput: one byte per cycle while m_tready stays high; the input
// register and the result register each hold one request, and the
// pattern compare plus window shift between them is combinational.
// Reset: hunting, empty window, both patterns zero, no pending result.
// Stall: a result holds while m_tready is low; s_tready drops once the
// input register is occupied and the result register holds an untaken one.
`timescale 1ns / 1ps
`default_nettype none

module delimited_frame_extractor #(
	parameter int START_BYTES = dfx_pkg::DEF_START_BYTES,
	parameter int END_BYTES   = dfx_pkg::DEF_END_BYTES,
	parameter int MAX_FRAME   = dfx_pkg::DEF_MAX_FRAME
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [dfx_pkg::BYTE_W-1:0]      s_tdata,   // [7:0] rx_byte
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [dfx_pkg::M_TDATA_W-1:0]        m_tdata,   // [7:0] payload_byte, [20:8] frame_length
	output logic                                 m_tuser,   // [0] kind
	input  wire logic                            cfg_we,
	input  wire logic [dfx_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [dfx_pkg::MARKER_W-1:0]    cfg_data
);
	import dfx_pkg::*;

	logic [MARKER_W-1:0] start_marker_q;
	logic [MARKER_W-1:0] end_marker_q;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              step;
	logic              res_valid;
	result_t           res;
	result_t           out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= '0;
			end_marker_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_MARKER: start_marker_q <= cfg_data;
				REG_END_MARKER:   end_marker_q   <= cfg_data;
			endcase
		end
	end

	// advance the input register when the result slot is free or being taken
	assign step     = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			byte_s1 <= s_tdata;
	end

	dfx_core #(
		.START_BYTES (START_BYTES),
		.END_BYTES   (END_BYTES),
		.MAX_FRAME   (MAX_FRAME)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.rx_byte      (byte_s1),
		.start_marker (start_marker_q),
		.end_marker   (end_marker_q),
		.res_valid    (res_valid),
		.res          (res)
	);

	dfx_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step),
		.res_valid (res_valid),
		.res       (res),
		.take      (m_tready),
		.out_valid (m_tvalid),
		.out_res   (out_res)
	);

	assign m_tdata = M_TDATA_W'({out_res.frame_length, out_res.payload_byte});
	assign m_tuser = out_res.kind;

endmodule

`default_nettype wire
